/* sv/cdq_pkg.sv */
// Shared types and constants for the circular deque.
package cdq_pkg;

    localparam int DEPTH_DEF      = 8;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_REAR  = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

/* sv/cdq_if.sv */
// Command and result channel interfaces of the circular deque.
interface cdq_in_if
    import cdq_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           command;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, command, value, input ready);
    modport sink   (input valid, command, value, output ready);
endinterface

interface cdq_out_if
    import cdq_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  data_out;
    logic [OCC_W-1:0]           occupancy;

    modport source (output valid, status, data_out, occupancy, input ready);
    modport sink   (input valid, status, data_out, occupancy, output ready);
endinterface

/* sv/cdq_mem.sv */
// Single-port entry store with registered read data.
module cdq_mem
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  t_mem_ctl                      i_ctl,
    input  logic [$clog2(DEPTH)-1:0]      i_addr,
    input  logic [DATA_WIDTH-1:0]         i_wr_data,
    output logic [DATA_WIDTH-1:0]         o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/cdq_ptr.sv */
// Head, tail and count registers with command decode and store addressing.
module cdq_ptr
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [CMD_W-1:0]                i_command,
    output t_mem_ctl                        o_mem_ctl,
    output logic [$clog2(DEPTH)-1:0]        o_addr,
    output t_status                         o_status,
    output logic [$clog2(DEPTH+1)-1:0]      o_count,
    output logic [$clog2(DEPTH+1)-1:0]      o_next_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] head_prev, head_next, tail_prev, tail_next;
    logic             full, empty, wr, rd;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    // Wrap explicitly so any depth works, not just powers of two
    assign head_prev = (r_head == '0)  ? LAST : r_head - PTR_W'(1);
    assign head_next = (r_head == LAST) ? '0  : r_head + PTR_W'(1);
    assign tail_prev = (r_tail == '0)  ? LAST : r_tail - PTR_W'(1);
    assign tail_next = (r_tail == LAST) ? '0  : r_tail + PTR_W'(1);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        o_status = STAT_OK;
        o_addr   = r_head;
        wr       = 1'b0;
        rd       = 1'b0;
        unique case (i_command)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                if (full) begin
                    o_status = STAT_FULL;
                end else begin
                    wr      = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    if (empty) begin
                        n_head = '0;
                        n_tail = '0;
                        o_addr = '0;
                    end else if (i_command == CMD_PUSH_FRONT) begin
                        n_head = head_prev;
                        o_addr = head_prev;
                    end else begin
                        n_tail = tail_next;
                        o_addr = tail_next;
                    end
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    o_status = STAT_EMPTY;
                end else begin
                    rd      = 1'b1;
                    o_addr  = r_head;
                    n_count = r_count - CNT_W'(1);
                    if (r_count > CNT_W'(1)) begin
                        n_head = head_next;
                    end
                end
            end
            CMD_POP_REAR: begin
                if (empty) begin
                    o_status = STAT_EMPTY;
                end else begin
                    rd      = 1'b1;
                    o_addr  = r_tail;
                    n_count = r_count - CNT_W'(1);
                    if (r_count > CNT_W'(1)) begin
                        n_tail = tail_prev;
                    end
                end
            end
            CMD_PEEK_FRONT: begin
                if (empty) begin
                    o_status = STAT_EMPTY;
                end else begin
                    rd     = 1'b1;
                    o_addr = r_head;
                end
            end
            CMD_PEEK_REAR: begin
                if (empty) begin
                    o_status = STAT_EMPTY;
                end else begin
                    rd     = 1'b1;
                    o_addr = r_tail;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_mem_ctl.wr_en = i_accept && wr;
    assign o_mem_ctl.rd_en = i_accept && rd;
    assign o_count         = r_count;
    assign o_next_count    = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule

/* sv/circular_deque.sv */
// Top level of the circular deque: sequencing, result register and checks.
//
//  channel   dir  modport  payload
//  i_in      in   sink     command[2:0], value[31:0] signed
//  o_out     out  source   status[1:0], data_out[31:0] signed, occupancy[3:0]
//
// Push, fault and unused commands load the result register directly; pops and peeks
// pass through the S_READ state first, since the entry store registers its read data.
// Synchronous active-low reset clears pointers, count and result valid;
// the store itself is not cleared and needs no sweep.
// A new transaction is taken once the result register is empty or being drained
// and no store read is in progress, so a pop or peek holds the input during S_READ.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cdq_in_if.sink          i_in,
    cdq_out_if.source       o_out
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_state                  r_state, n_state;
    t_mem_ctl                mem_ctl;
    t_status                 cmd_status;
    logic [PTR_W-1:0]        mem_addr;
    logic [DATA_WIDTH-1:0]   rd_data;
    logic [CNT_W-1:0]        count, next_count;
    logic                    accept, in_ready, load_read;

    logic                    r_out_valid;
    t_status                 r_status;
    logic [VALUE_W-1:0]      r_data_out;
    logic [OCC_W-1:0]        r_occupancy;

    assign accept = i_in.valid && in_ready;

    cdq_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (i_in.command),
        .o_mem_ctl    (mem_ctl),
        .o_addr       (mem_addr),
        .o_status     (cmd_status),
        .o_count      (count),
        .o_next_count (next_count)
    );

    cdq_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_addr    (mem_addr),
        .i_wr_data (DATA_WIDTH'(i_in.value)),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (mem_ctl.rd_en) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        load_read = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = !r_out_valid || o_out.ready;
            end
            S_READ: begin
                load_read = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_read || (accept && !mem_ctl.rd_en)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Store word comes back zero-extended; the count is already updated
    always_ff @(posedge i_clk) begin
        if (load_read) begin
            r_status    <= STAT_OK;
            r_data_out  <= VALUE_W'(rd_data);
            r_occupancy <= OCC_W'(count);
        end else if (accept && !mem_ctl.rd_en) begin
            r_status    <= cmd_status;
            r_data_out  <= '0;
            r_occupancy <= OCC_W'(next_count);
        end
    end

    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_status;
    assign o_out.data_out  = r_data_out;
    assign o_out.occupancy = r_occupancy;

    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("result register occupied during store read");

    a_read_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && mem_ctl.rd_en) |=> (r_state == S_READ) && !in_ready)
        else $error("read transaction not followed by read cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CNT_W'(DEPTH))
        else $error("occupancy beyond capacity");

    a_fault_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (cmd_status != STAT_OK)) |=> $stable(count))
        else $error("refused command changed occupancy");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the circular deque: directed corners, then random traffic.
`timescale 1ns / 1ps

module testbench;
    import cdq_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
    localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] WORD_ONES = -32'sd1;

    typedef struct {
        t_status                    status;
        logic signed [VALUE_W-1:0]  data;
        logic [OCC_W-1:0]           occ;
    } t_deque_result;

    logic clk;
    logic rst_n;

    cdq_in_if  cmd_if ();
    cdq_out_if res_if ();

    circular_deque uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    // Mirror of the deque contents
    logic signed [VALUE_W-1:0] model_slot [DEPTH];
    int model_head;
    int model_tail;
    int model_count;

    t_deque_result pending_results [$];
    int error_count;
    bit burst_mode;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial begin
        #2_000_000;
        $display("circular_deque regression: fail");
        $finish;
    end

    function automatic t_deque_result deque_apply(logic [CMD_W-1:0] cmd,
                                                  logic signed [VALUE_W-1:0] word);
        t_deque_result r;
        logic front;
        r.status = STAT_OK;
        r.data   = '0;
        front    = (cmd == CMD_POP_FRONT) || (cmd == CMD_PEEK_FRONT);
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                if (model_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    if (model_count == 0) begin
                        model_head = 0;
                        model_tail = 0;
                        model_slot[0] = word;
                    end else if (cmd == CMD_PUSH_FRONT) begin
                        model_head = (model_head + DEPTH - 1) % DEPTH;
                        model_slot[model_head] = word;
                    end else begin
                        model_tail = (model_tail + 1) % DEPTH;
                        model_slot[model_tail] = word;
                    end
                    model_count++;
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR, CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
                if (model_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.data = model_slot[front ? model_head : model_tail];
                    if (cmd == CMD_POP_FRONT) begin
                        if (model_count > 1) model_head = (model_head + 1) % DEPTH;
                        model_count--;
                    end else if (cmd == CMD_POP_REAR) begin
                        if (model_count > 1) model_tail = (model_tail + DEPTH - 1) % DEPTH;
                        model_count--;
                    end
                end
            end
            default: begin
            end
        endcase
        r.occ = model_count[OCC_W-1:0];
        return r;
    endfunction

    function automatic int draw_gap();
        if (burst_mode) return 0;
        return $urandom_range(0, 1) ? 0 : $urandom_range(0, 18);
    endfunction

    // Hold valid across back-to-back transactions; lower it only for a gap
    task automatic send_command(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] word);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= cmd;
        cmd_if.value   <= word;
        do @(posedge clk); while (!cmd_if.ready);
        pending_results.push_back(deque_apply(cmd, word));
    endtask

    task automatic wait_for_drain();
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic logic [CMD_W-1:0] pick_command(int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) return $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
        if (roll < 3 + push_pct) return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
        case ($urandom_range(0, 5))
            0, 1:    return CMD_POP_FRONT;
            2, 3:    return CMD_POP_REAR;
            4:       return CMD_PEEK_FRONT;
            default: return CMD_PEEK_REAR;
        endcase
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return WORD_ONES;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_faults();
        send_command(CMD_POP_FRONT, WORD_ONES);
        send_command(CMD_POP_REAR, WORD_MIN);
        send_command(CMD_PEEK_FRONT, WORD_MAX);
        send_command(CMD_PEEK_REAR, '0);
        send_command(CMD_SPARE_A, WORD_ONES);
        send_command(CMD_SPARE_B, WORD_MIN);
    endtask

    // Fill from both ends, bounce off full, then empty from both ends
    task automatic test_fill_and_empty();
        send_command(CMD_PUSH_REAR, WORD_MIN);
        send_command(CMD_PUSH_FRONT, WORD_MAX);
        send_command(CMD_PUSH_FRONT, '0);
        send_command(CMD_PUSH_REAR, WORD_ONES);
        send_command(CMD_PUSH_FRONT, 32'sh5A5A_A5A5);
        send_command(CMD_PUSH_FRONT, 32'sh1234_5678);
        send_command(CMD_PUSH_REAR, 32'sh0F0F_F0F0);
        send_command(CMD_PUSH_REAR, -32'sd2);
        send_command(CMD_PUSH_FRONT, 32'sh1111_1111);
        send_command(CMD_PUSH_REAR, 32'sh2222_2222);
        send_command(CMD_PEEK_FRONT, '0);
        send_command(CMD_PEEK_REAR, '0);
        repeat (4) send_command(CMD_POP_FRONT, WORD_ONES);
        repeat (4) send_command(CMD_POP_REAR, WORD_ONES);
    endtask

    task automatic test_random_walk(int items, int push_pct);
        repeat (items) send_command(pick_command(push_pct), pick_word());
    endtask

    task automatic test_back_to_back(int items);
        burst_mode = 1'b1;
        test_random_walk(items, 50);
        burst_mode = 1'b0;
    endtask

    // Result checker
    initial begin
        t_deque_result exp_r;
        int stall;
        res_if.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d data_out %0d occupancy %0d",
                       res_if.status, res_if.data_out, res_if.occupancy);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (res_if.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, res_if.status);
                    error_count++;
                end
                if (res_if.data_out !== exp_r.data) begin
                    $error("data_out: expected %0d, got %0d", exp_r.data, res_if.data_out);
                    error_count++;
                end
                if (res_if.occupancy !== exp_r.occ) begin
                    $error("occupancy: expected %0d, got %0d", exp_r.occ, res_if.occupancy);
                    error_count++;
                end
            end
        end
    end

    initial begin
        error_count = 0;
        burst_mode  = 1'b0;
        model_head  = 0;
        model_tail  = 0;
        model_count = 0;
        foreach (model_slot[i]) model_slot[i] = '0;
        rst_n          <= 1'b0;
        cmd_if.valid   <= 1'b0;
        cmd_if.command <= '0;
        cmd_if.value   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_faults();
        test_fill_and_empty();
        test_random_walk(150, 70);
        test_random_walk(150, 25);
        wait_for_drain();
        test_back_to_back(60);
        test_random_walk(150, 50);
        test_random_walk(150, 60);

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (error_count == 0) begin
            $display("circular_deque regression: pass");
        end else begin
            $display("circular_deque regression: fail");
        end
        $finish;
    end

endmodule
